@@ sv/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// shared types and constants of the indexed list store
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int LIST_CAPACITY = 64;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 16;
    localparam int OP_W          = 3;
    localparam int LEN_W         = 7;

    localparam logic [DATA_W-1:0] READ_MISS = '1;

    typedef enum logic [OP_W-1:0] {
        OP_READ     = 3'd0,
        OP_ADD_HEAD = 3'd1,
        OP_ADD_TAIL = 3'd2,
        OP_INSERT   = 3'd3,
        OP_DELETE   = 3'd4
    } t_op;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cmd;

endpackage

@@ sv/ils_cell.sv @@
// ----------------------------------------------------------------------------
// ils_cell
// one list entry: takes its left neighbour on insert, its right neighbour on
// delete, and drives its value onto the read bus when selected
// ----------------------------------------------------------------------------
module ils_cell
    import ils_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [IDX_W-1:0]  i_slot,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_rd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_IDX > i_slot) begin
                n_data = i_left;
            end else if (MY_IDX == i_slot) begin
                n_data = i_value;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_slot) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (MY_IDX == i_slot) ? r_data : '0;

endmodule

@@ sv/indexed_list_store_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// ordered list of signed 32-bit values kept in a row of shifting cells
// ----------------------------------------------------------------------------
// One request is taken per clock cycle unless a held result stalls it; its
// result is registered in the output register; a new request is taken while
// that result is being transferred. Every cell holds one entry and loads its
// neighbour in the same cycle, so insert and delete shift the whole list at
// once; a read selects the addressed cell over an and-or bus. The store starts
// empty after reset and needs no clearing pass; only entries below the count
// are read. An add or insert into a full store is refused with accepted low.
// ----------------------------------------------------------------------------
module indexed_list_store_unit
    import ils_pkg::*;
#(
    parameter int CAPACITY = LIST_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // opcode, position, item_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // read_value, accepted, length
    output logic        o_m_axis_tuser   // read_ok
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_value;
    logic              r_read_ok;
    logic              r_accepted;
    logic [LEN_W-1:0]  r_length;
    logic [CNT_W-1:0]  r_count;

    logic [CNT_W-1:0]  n_count;
    logic [DATA_W-1:0] n_read_value;
    logic              n_read_ok;
    logic              n_accepted;
    logic [LEN_W-1:0]  n_length;

    logic              in_xfer;
    t_op               op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos_u;
    logic [POS_W-1:0]  cnt_ext;
    logic              in_range;
    logic              full;
    logic              do_ins;
    logic              do_del;
    logic [IDX_W-1:0]  slot;
    t_cmd              cmd;
    logic [DATA_W-1:0] read_bus;
    logic [CNT_W+LEN_W-1:0] len_ext;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    assign op    = t_op'(i_s_axis_tdata[OP_W-1:0]);
    assign pos   = i_s_axis_tdata[OP_W+POS_W-1:OP_W];
    assign value = i_s_axis_tdata[OP_W+POS_W+DATA_W-1:OP_W+POS_W];

    assign pos_u    = {1'b0, pos[POS_W-2:0]};
    assign cnt_ext  = POS_W'(r_count);
    assign in_range = !pos[POS_W-1] && (pos_u < cnt_ext);
    assign full     = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        do_ins       = 1'b0;
        do_del       = 1'b0;
        slot         = pos_u[IDX_W-1:0];
        n_read_value = '0;
        n_read_ok    = 1'b0;
        case (op)
            OP_READ: begin
                if (in_range) begin
                    n_read_value = read_bus;
                    n_read_ok    = 1'b1;
                end else begin
                    n_read_value = READ_MISS;
                end
            end
            OP_ADD_HEAD: begin
                do_ins = !full;
                slot   = '0;
            end
            OP_ADD_TAIL: begin
                do_ins = !full;
                slot   = r_count[IDX_W-1:0];
            end
            OP_INSERT: begin
                if (pos[POS_W-1]) begin
                    do_ins = !full;
                    slot   = '0;
                end else begin
                    do_ins = !full && (pos_u <= cnt_ext);
                end
            end
            OP_DELETE: begin
                do_del = in_range;
            end
            default: begin
                n_read_value = '0;
            end
        endcase
        n_accepted = do_ins || do_del || n_read_ok;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_del) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
        len_ext  = {{LEN_W{1'b0}}, n_count};
        n_length = len_ext[LEN_W-1:0];
    end

    assign cmd.ins = in_xfer && do_ins;
    assign cmd.del = in_xfer && do_del;

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = cell_data[g];
        end else begin : g_mid
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[g];
        end else begin : g_body
            assign right_d = cell_data[g+1];
        end
        ils_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_slot  (slot),
            .i_value (value),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[g]),
            .o_rd    (cell_rd[g])
        );
    end

    always_comb begin
        read_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            read_bus = read_bus | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_xfer) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_read_value <= n_read_value;
            r_read_ok    <= n_read_ok;
            r_accepted   <= n_accepted;
            r_length     <= n_length;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_length, r_accepted, r_read_value};
    assign o_m_axis_tuser  = r_read_ok;

endmodule

@@ sv/ils_checker.sv @@
// ----------------------------------------------------------------------------
// ils_checker
// port-level checks of the indexed list store
// ----------------------------------------------------------------------------
module ils_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // a good read is always an accepted request
    a_ok_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[32])
        else $error("read_ok without accepted");

    // empty output register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // each input transfer yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("transfer without result");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind indexed_list_store_unit ils_checker u_ils_checker (.*);

@@ verif/indexed_list_store_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_store_unit_checker
// watches both stream channels of the list store, keeps its own copy of the
// list, predicts the result of every accepted request and compares each
// result transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module indexed_list_store_unit_checker
    import ils_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [55:0] i_req_data,       // opcode, position, item_value
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [39:0] i_rsp_data,       // read_value, accepted, length
    input  logic        i_rsp_user,       // read_ok
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_refusals
);

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              read_ok;
        logic              accepted;
        logic [LEN_W-1:0]  length;
    } t_outcome;

    logic [DATA_W-1:0] list_vals[$];
    t_outcome          outcome_q[$];
    int                fail_cnt      = 0;
    int                checked_cnt   = 0;
    int                refusal_cnt   = 0;

    assign o_fail_count    = fail_cnt;
    assign o_pending       = outcome_q.size();
    assign o_checked       = checked_cnt;
    assign o_full_refusals = refusal_cnt;

    // open a slot and write the value, refused when the store is full
    function automatic logic place_value(int slot, logic [DATA_W-1:0] val);
        if (list_vals.size() >= LIST_CAPACITY) begin
            refusal_cnt++;
            return 1'b0;
        end
        list_vals.insert(slot, val);
        return 1'b1;
    endfunction

    function automatic t_outcome apply_list_request(logic [OP_W-1:0] op,
                                                    logic signed [POS_W-1:0] pos,
                                                    logic [DATA_W-1:0] val);
        t_outcome res;
        int       len;
        int       p;
        res = '0;
        len = list_vals.size();
        p   = pos;
        case (op)
            OP_READ: begin
                if (p >= 0 && p < len) begin
                    res.read_value = list_vals[p];
                    res.read_ok    = 1'b1;
                    res.accepted   = 1'b1;
                end else begin
                    res.read_value = READ_MISS;
                end
            end
            OP_ADD_HEAD: res.accepted = place_value(0, val);
            OP_ADD_TAIL: res.accepted = place_value(len, val);
            OP_INSERT: begin
                if (p < 0)
                    res.accepted = place_value(0, val);
                else if (p <= len)
                    res.accepted = place_value(p, val);
            end
            OP_DELETE: begin
                if (p >= 0 && p < len) begin
                    list_vals.delete(p);
                    res.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        res.length = LEN_W'(list_vals.size());
        return res;
    endfunction

    task automatic compare_field(string name, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                     act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                checked_cnt++;
                if (outcome_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result transfer with nothing expected, actual %0h/%0b",
                             $time, i_rsp_data, i_rsp_user);
                end else begin
                    exp_r = outcome_q.pop_front();
                    compare_field("read_value", exp_r.read_value, i_rsp_data[31:0]);
                    compare_field("accepted", DATA_W'(exp_r.accepted), DATA_W'(i_rsp_data[32]));
                    compare_field("length", DATA_W'(exp_r.length), DATA_W'(i_rsp_data[39:33]));
                    compare_field("read_ok", DATA_W'(exp_r.read_ok), DATA_W'(i_rsp_user));
                end
            end
            if (i_req_valid && i_req_ready)
                outcome_q.push_back(apply_list_request(i_req_data[2:0], i_req_data[18:3],
                                                       i_req_data[50:19]));
        end
    end

endmodule

@@ verif/indexed_list_store_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_store_unit_tb
// drives read, add, insert and delete requests into the list store with
// random gaps and back-pressure; a directed opening covers empty, edge and
// invalid positions, then random grow, shrink and mixed phases follow and exercise it
// ----------------------------------------------------------------------------
module indexed_list_store_unit_tb;
    import ils_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 1250;

    typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIXED} t_phase;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // opcode, position, item_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // read_value, accepted, length
    logic        m_tuser;         // read_ok

    int fail_count;
    int pending;
    int checked;
    int full_refusals;
    int est_len  = 0;
    int peak_len = 0;
    bit no_idle  = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    indexed_list_store_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    indexed_list_store_unit_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (s_tvalid),
        .i_req_ready     (s_tready),
        .i_req_data      (s_tdata),
        .i_rsp_valid     (m_tvalid),
        .i_rsp_ready     (m_tready),
        .i_rsp_data      (m_tdata),
        .i_rsp_user      (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_refusals (full_refusals)
    );

    // rough list length, used to aim positions near the live range and to track the peak depth
    task automatic track_length(logic [OP_W-1:0] op, logic [POS_W-1:0] pos);
        int p;
        p = $signed(pos);
        case (op)
            OP_ADD_HEAD, OP_ADD_TAIL: if (est_len < LIST_CAPACITY) est_len++;
            OP_INSERT: if (est_len < LIST_CAPACITY && p <= est_len) est_len++;
            OP_DELETE: if (p >= 0 && p < est_len) est_len--;
            default: ;
        endcase
        if (est_len > peak_len)
            peak_len = est_len;
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [DATA_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, pos, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        track_length(op, pos);
    endtask

    function automatic logic [OP_W-1:0] pick_op(t_phase ph);
        int cut[5];
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_GROW:   cut = '{20, 40, 55, 80, 95};
            PH_SHRINK: cut = '{20, 25, 30, 40, 95};
            default:   cut = '{25, 40, 55, 75, 97};
        endcase
        if (r < cut[0])      return OP_READ;
        else if (r < cut[1]) return OP_ADD_HEAD;
        else if (r < cut[2]) return OP_ADD_TAIL;
        else if (r < cut[3]) return OP_INSERT;
        else if (r < cut[4]) return OP_DELETE;
        return OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 4) == 0)
            return POS_W'($urandom());
        return POS_W'(int'($urandom_range(0, est_len + 3)) - 2);
    endfunction

    initial begin : rsp_side
        int rsp_gap;
        wait (rst_n);
        forever begin
            rsp_gap = no_idle ? 0 : $urandom_range(0, 3);
            if (rsp_gap > 0) begin
                m_tready <= 1'b0;
                repeat (rsp_gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial begin : stimulus
        int     sent;
        int     phase_len;
        t_phase ph;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty store: misses and ignored requests
        send_request(OP_READ, 16'sd0, $urandom());
        send_request(OP_READ, 16'h8000, $urandom());
        send_request(OP_DELETE, 16'sd0, $urandom());
        send_request(OP_INSERT, 16'sd1, $urandom());
        // head on negative insert, value extremes
        send_request(OP_INSERT, -16'sd1, 32'h7fff_ffff);
        send_request(OP_ADD_HEAD, POS_W'($urandom()), 32'h8000_0000);
        send_request(OP_ADD_TAIL, POS_W'($urandom()), 32'hffff_ffff);
        send_request(OP_INSERT, 16'sd3, 32'h0000_0000);
        send_request(OP_INSERT, 16'sd1, $urandom());
        send_request(OP_READ, 16'sd0, $urandom());
        send_request(OP_READ, 16'sd4, $urandom());
        send_request(OP_READ, 16'sd5, $urandom());
        send_request(OP_READ, 16'h7fff, $urandom());
        send_request(OP_READ, 16'hffff, $urandom());
        send_request(OP_INSERT, 16'h7fff, $urandom());
        send_request(OP_DELETE, 16'sd4, $urandom());
        send_request(OP_DELETE, 16'sd0, $urandom());
        send_request(OP_DELETE, 16'h7fff, $urandom());
        send_request(OP_DELETE, 16'hffff, $urandom());
        send_request(OP_UNUSED_FIRST, POS_W'($urandom()), $urandom());
        send_request(OP_UNUSED_FIRST + 3'd1, POS_W'($urandom()), $urandom());
        send_request(OP_UNUSED_LAST, POS_W'($urandom()), $urandom());
        send_request(OP_READ, 16'sd1, $urandom());

        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 200);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            ph        = t_phase'($urandom_range(0, 2));
            no_idle   = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                send_request(pick_op(ph), pick_pos(), $urandom());
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        no_idle  = 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
        $display("%0d results checked over random grow, drain and mixed phases", checked);
        $display("list depth peaked at %0d, %0d requests refused on a full store",
                 peak_len, full_refusals);
        if (fail_count == 0)
            $display("indexed_list_store_unit test passed");
        else
            $display("indexed_list_store_unit test failed");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("indexed_list_store_unit test failed");
        $finish;
    end

endmodule
